@@ rtl/cas_pkg.sv @@
// Shared types, constants and helpers for the cave automaton smoothing block.
// No dependencies; imported by the line buffer, the cell rule and the top level.
package cas_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 1024;

    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int ROW_W    = $clog2(MAX_HEIGHT);
    localparam int WIDTH_W  = 9;
    localparam int HEIGHT_W = 11;
    localparam int KIND_W   = 3;
    localparam int THR_W    = 3;
    localparam int CNT_W    = 3;
    localparam int IDX_W    = 3;
    localparam int CFG_W    = 11;

    typedef logic [KIND_W-1:0] kind_t;

    localparam kind_t KIND_OPEN     = 3'd0;
    localparam kind_t KIND_OBSTACLE = 3'd1;
    localparam kind_t KIND_SPECIAL  = 3'd2;

    localparam logic [IDX_W-1:0] REG_UPDATE_MODE = 3'd0;
    localparam logic [IDX_W-1:0] REG_SURVIVAL    = 3'd1;
    localparam logic [IDX_W-1:0] REG_BIRTH       = 3'd2;
    localparam logic [IDX_W-1:0] REG_WIDTH       = 3'd3;
    localparam logic [IDX_W-1:0] REG_HEIGHT      = 3'd4;

    // position of the centre cell, worked out when its south neighbour arrives
    typedef struct packed {
        logic row_ge2;
        logic col_border;
    } cell_pos_t;

    function automatic logic [CNT_W-1:0] is_obstacle(input kind_t k);
        return (k == KIND_OBSTACLE) ? CNT_W'(1) : CNT_W'(0);
    endfunction

endpackage

@@ rtl/cas_line_buf.sv @@
// Two row line buffers: updated row above and original centre row.
// Depends on cas_pkg. Read data is registered; no clearing after reset.
module cas_line_buf (
    input  logic                      clk,
    input  logic                      rd_en,
    input  logic [cas_pkg::COL_W-1:0] rd_addr,
    input  logic [cas_pkg::COL_W-1:0] rd_addr_east,
    input  logic                      wr_above,
    input  logic                      wr_center,
    input  logic [cas_pkg::COL_W-1:0] wr_addr,
    input  cas_pkg::kind_t            above_wdata,
    input  cas_pkg::kind_t            center_wdata,
    output cas_pkg::kind_t            north,
    output cas_pkg::kind_t            centre,
    output cas_pkg::kind_t            east
);
    import cas_pkg::*;

    kind_t above_mem  [MAX_WIDTH];
    kind_t center_mem [MAX_WIDTH];
    kind_t north_reg;
    kind_t centre_reg;
    kind_t east_reg;

    always_ff @(posedge clk)
    begin
        if (wr_above)
        begin
            above_mem[wr_addr] <= above_wdata;
        end
        if (wr_center)
        begin
            center_mem[wr_addr] <= center_wdata;
        end
        if (rd_en)
        begin
            north_reg  <= above_mem[rd_addr];
            centre_reg <= center_mem[rd_addr];
            east_reg   <= center_mem[rd_addr_east];
        end
    end

    assign north  = north_reg;
    assign centre = centre_reg;
    assign east   = east_reg;

endmodule

@@ rtl/cas_cell_rule.sv @@
// Four-neighbour smoothing rule for one centre cell.
// Depends on cas_pkg. Purely combinational.
module cas_cell_rule (
    input  cas_pkg::kind_t            centre,
    input  cas_pkg::kind_t            north,
    input  cas_pkg::kind_t            west,
    input  cas_pkg::kind_t            east,
    input  cas_pkg::kind_t            south,
    input  cas_pkg::cell_pos_t        pos,
    input  logic [cas_pkg::THR_W-1:0] survival,
    input  logic [cas_pkg::THR_W-1:0] birth,
    input  logic                      sync_mode,
    output cas_pkg::kind_t            result,
    output cas_pkg::kind_t            write_back
);
    import cas_pkg::*;

    logic [CNT_W-1:0] count;
    logic             interior;

    always_comb
    begin
        count    = is_obstacle(north) + is_obstacle(west) + is_obstacle(east)
                 + is_obstacle(south);
        interior = pos.row_ge2 && !pos.col_border && (centre != KIND_SPECIAL);
        result   = centre;
        if (interior)
        begin
            if (count < survival)
            begin
                result = KIND_OPEN;
            end
            else if (count >= birth)
            begin
                result = KIND_OBSTACLE;
            end
        end
        // synchronous pass keeps originals for north and west
        write_back = sync_mode ? centre : result;
    end

endmodule

@@ rtl/cave_automaton_smoothing.sv @@
// Top level of the cave automaton smoothing block: counters, config, work stage
// and output register. Depends on cas_pkg, cas_line_buf and cas_cell_rule.
//
// Usage:
//   Cells of the grid enter on the s_ channel in raster order, one per beat,
//   frame_start on s_tuser marking the first cell of a pass. Results leave on
//   the m_ channel: each cell of row r emits the finished cell of row r-1, and
//   each cell of the last row then also emits itself. m_tlast marks the last
//   result of the pass, m_tuser the last result caused by an input beat.
//   Registers are to be written by the user through cfg_we/cfg_index/cfg_data
//   only while idle; the block itself does not enforce this. An accepted input
//   beat loads the work stage and the line buffer read registers; the output
//   register is loaded from them when it is free, and with the second beat of a
//   last-row cell once the first has been taken.
//   Throughput: one input beat per cycle while the output register is free,
//   set by the single work stage between the line buffer read and the output
//   register; last-row cells need two output beats and hold the stage for both.
//   The first row gives no result.
//   Reset clears counters, valid flags and the west cell and loads register
//   defaults; line buffers are not cleared. When m_tready is low the output
//   register holds its beat and one cell waits in the work stage; s_tready
//   drops only once that cell cannot move on.
module cave_automaton_smoothing (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [7:0]                s_tdata,   // [2:0] cell_kind
    input  logic                      s_tuser,   // [0] frame_start
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [7:0]                m_tdata,   // [2:0] new_kind
    output logic                      m_tlast,   // frame_end
    output logic                      m_tuser,   // [0] run_last
    input  logic                      cfg_we,
    input  logic [cas_pkg::IDX_W-1:0] cfg_index,
    input  logic [cas_pkg::CFG_W-1:0] cfg_data
);
    import cas_pkg::*;

    // configuration
    logic                mode_reg;
    logic [THR_W-1:0]    surv_reg;
    logic [THR_W-1:0]    birth_reg;
    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [WIDTH_W-1:0]  w_eff;
    logic [HEIGHT_W-1:0] h_eff;

    // raster position
    logic [COL_W-1:0]    col_reg;
    logic [ROW_W-1:0]    row_reg;
    logic [COL_W-1:0]    col_next;
    logic [ROW_W-1:0]    row_next;
    logic [COL_W-1:0]    cur_col;
    logic [ROW_W-1:0]    cur_row;
    logic [HEIGHT_W-1:0] row_pre;
    logic [WIDTH_W-1:0]  col_inc;
    logic [HEIGHT_W-1:0] row_adv;
    logic                wrap_col;

    // work stage
    logic                s1_valid_reg;
    logic                s1_phase_reg;
    logic                s1_valid_next;
    logic                s1_phase_next;
    kind_t               s1_kind_reg;
    logic [COL_W-1:0]    s1_col_reg;
    logic                s1_row_ge1_reg;
    logic                s1_last_row_reg;
    logic                s1_col_last_reg;
    cell_pos_t           s1_pos_reg;
    kind_t               west_reg;

    kind_t               north;
    kind_t               centre;
    kind_t               east;
    kind_t               result;
    kind_t               write_back;

    logic                in_accept;
    logic                out_free;
    logic                first_pending;
    logic                need_out;
    logic                push;
    logic                done;

    // output register
    logic                out_valid_reg;
    kind_t               out_kind_reg;
    logic                out_last_reg;
    logic                out_run_last_reg;

    always_comb
    begin
        w_eff = width_reg;
        if (width_reg < WIDTH_W'(3))
        begin
            w_eff = WIDTH_W'(3);
        end
        else if (width_reg > WIDTH_W'(MAX_WIDTH))
        begin
            w_eff = WIDTH_W'(MAX_WIDTH);
        end
        h_eff = height_reg;
        if (height_reg < HEIGHT_W'(3))
        begin
            h_eff = HEIGHT_W'(3);
        end
        else if (height_reg > HEIGHT_W'(MAX_HEIGHT))
        begin
            h_eff = HEIGHT_W'(MAX_HEIGHT);
        end
    end

    // counters may sit beyond a size reduced since the last beat
    always_comb
    begin
        wrap_col = WIDTH_W'(col_reg) >= w_eff;
        row_pre  = wrap_col ? (HEIGHT_W'(row_reg) + HEIGHT_W'(1)) : HEIGHT_W'(row_reg);
        cur_col  = wrap_col ? '0 : col_reg;
        cur_row  = (row_pre >= h_eff) ? '0 : row_pre[ROW_W-1:0];
        if (s_tuser)
        begin
            cur_col = '0;
            cur_row = '0;
        end
        col_inc = WIDTH_W'(cur_col) + WIDTH_W'(1);
        row_adv = HEIGHT_W'(cur_row) + HEIGHT_W'(1);
        if (col_inc >= w_eff)
        begin
            col_next = '0;
            row_next = (row_adv >= h_eff) ? '0 : row_adv[ROW_W-1:0];
        end
        else
        begin
            col_next = col_inc[COL_W-1:0];
            row_next = cur_row;
        end
    end

    always_comb
    begin
        out_free      = !out_valid_reg || m_tready;
        first_pending = s1_row_ge1_reg && !s1_phase_reg;
        need_out      = first_pending || s1_last_row_reg;
        push          = s1_valid_reg && need_out && out_free;
        done          = s1_valid_reg
                     && (!need_out || (push && !(first_pending && s1_last_row_reg)));
        s_tready      = !s1_valid_reg || done;
        in_accept     = s_tvalid && s_tready;

        s1_valid_next = s1_valid_reg;
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (done)
        begin
            s1_valid_next = 1'b0;
        end

        s1_phase_next = s1_phase_reg;
        if (done)
        begin
            s1_phase_next = 1'b0;
        end
        else if (push)
        begin
            s1_phase_next = 1'b1;
        end
    end

    cas_line_buf u_line_buf (
        .clk          (clk),
        .rd_en        (in_accept),
        .rd_addr      (cur_col),
        .rd_addr_east (cur_col + COL_W'(1)),
        .wr_above     (done && s1_row_ge1_reg),
        .wr_center    (done),
        .wr_addr      (s1_col_reg),
        .above_wdata  (write_back),
        .center_wdata (s1_kind_reg),
        .north        (north),
        .centre       (centre),
        .east         (east)
    );

    cas_cell_rule u_cell_rule (
        .centre     (centre),
        .north      (north),
        .west       (west_reg),
        .east       (east),
        .south      (s1_kind_reg),
        .pos        (s1_pos_reg),
        .survival   (surv_reg),
        .birth      (birth_reg),
        .sync_mode  (mode_reg),
        .result     (result),
        .write_back (write_back)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= 1'b1;
            surv_reg   <= THR_W'(2);
            birth_reg  <= THR_W'(3);
            width_reg  <= WIDTH_W'(64);
            height_reg <= HEIGHT_W'(64);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_UPDATE_MODE: mode_reg   <= cfg_data[0];
                REG_SURVIVAL:    surv_reg   <= cfg_data[THR_W-1:0];
                REG_BIRTH:       birth_reg  <= cfg_data[THR_W-1:0];
                REG_WIDTH:       width_reg  <= cfg_data[WIDTH_W-1:0];
                REG_HEIGHT:      height_reg <= cfg_data[HEIGHT_W-1:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            s1_phase_reg  <= 1'b0;
            west_reg      <= KIND_OPEN;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            s1_valid_reg <= s1_valid_next;
            s1_phase_reg <= s1_phase_next;
            if (done && s1_row_ge1_reg)
            begin
                west_reg <= write_back;
            end
            if (push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_kind_reg           <= s_tdata[KIND_W-1:0];
            s1_col_reg            <= cur_col;
            s1_row_ge1_reg        <= (cur_row != '0);
            s1_last_row_reg       <= (HEIGHT_W'(cur_row) == h_eff - HEIGHT_W'(1));
            s1_col_last_reg       <= (WIDTH_W'(cur_col) == w_eff - WIDTH_W'(1));
            s1_pos_reg.row_ge2    <= (cur_row > ROW_W'(1));
            s1_pos_reg.col_border <= (cur_col == '0)
                                  || (WIDTH_W'(cur_col) == w_eff - WIDTH_W'(1));
        end
        if (push)
        begin
            if (first_pending)
            begin
                out_kind_reg     <= result;
                out_last_reg     <= 1'b0;
                out_run_last_reg <= !s1_last_row_reg;
            end
            else
            begin
                out_kind_reg     <= s1_kind_reg;
                out_last_reg     <= s1_col_last_reg;
                out_run_last_reg <= 1'b1;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(8 - KIND_W){1'b0}}, out_kind_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_run_last_reg;

endmodule

@@ rtl/cas_checker.sv @@
// Port-level checks on the result stream of the cave automaton smoothing block,
// bound to the top. No dependencies beyond the top level's port names.
module cas_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast,
    input logic       m_tuser
);

    // a stalled beat stays
    a_hold_valid : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("m_tvalid dropped while stalled");

    a_hold_data : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser))
        else $error("output beat changed while stalled");

    // end of pass is always the last beat of its cell
    a_frame_end_run_last : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tuser)
        else $error("frame end without run_last");

    // the second beat of a last-row cell follows straight after the first
    a_pair_back_to_back : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tuser |=> m_tvalid && m_tuser)
        else $error("second result of a cell not presented next cycle");

endmodule

bind cave_automaton_smoothing cas_checker u_cas_checker (.*);

@@ tb/sv/cave_automaton_smoothing_test.sv @@
// Self-checking bench for cave_automaton_smoothing: random grids in raster order,
// a tracker that works out each smoothed tile, random idling on both streams.
// Depends on cas_pkg and the cave_automaton_smoothing RTL.
module cave_automaton_smoothing_test;

    timeunit 1ns;
    timeprecision 1ps;

    import cas_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 64;
    localparam int DRAIN_CYCLES = 4;

    typedef struct {
        kind_t kind;
        bit    frame_end;
        bit    run_last;
    } tile_t;

    // Tracks the grid pass and queues the tiles the block should emit.
    class cave_grid_tracker;
        kind_t             above_row [MAX_WIDTH];
        kind_t             centre_row [MAX_WIDTH];
        kind_t             west_kind;
        int unsigned       col;
        int unsigned       row;
        bit                sync_mode;
        bit [THR_W-1:0]    survive_min;
        bit [THR_W-1:0]    birth_min;
        bit [WIDTH_W-1:0]  width_reg;
        bit [HEIGHT_W-1:0] height_reg;
        tile_t             pending_tiles [$];
        int                mismatch_count;

        function new();
            foreach (above_row[i])
            begin
                above_row[i]  = KIND_OPEN;
                centre_row[i] = KIND_OPEN;
            end
            west_kind      = KIND_OPEN;
            col            = 0;
            row            = 0;
            sync_mode      = 1'b1;
            survive_min    = 2;
            birth_min      = 3;
            width_reg      = 64;
            height_reg     = 64;
            mismatch_count = 0;
        endfunction

        function int unsigned fit(int unsigned v, int unsigned hi);
            if (v < 3)
                return 3;
            if (v > hi)
                return hi;
            return v;
        endfunction

        function int unsigned cols();
            return fit(width_reg, MAX_WIDTH);
        endfunction

        function int unsigned rows();
            return fit(height_reg, MAX_HEIGHT);
        endfunction

        function int pending();
            return pending_tiles.size();
        endfunction

        function void queue_tile(kind_t kind, bit frame_end, bit run_last);
            tile_t tile;
            tile.kind      = kind;
            tile.frame_end = frame_end;
            tile.run_last  = run_last;
            pending_tiles.insert(pending_tiles.size(), tile);
        endfunction

        function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                REG_UPDATE_MODE: sync_mode   = data[0];
                REG_SURVIVAL:    survive_min = data[THR_W-1:0];
                REG_BIRTH:       birth_min   = data[THR_W-1:0];
                REG_WIDTH:       width_reg   = data[WIDTH_W-1:0];
                REG_HEIGHT:      height_reg  = data[HEIGHT_W-1:0];
                default:         ;
            endcase
        endfunction

        function void note_cell(kind_t kind, bit start);
            int unsigned w;
            int unsigned h;
            int          n;
            kind_t       centre;
            kind_t       smoothed;
            w = cols();
            h = rows();
            if (col >= w)
            begin
                col = 0;
                row++;
            end
            if (row >= h)
                row = 0;
            if (start)
            begin
                col = 0;
                row = 0;
            end
            // the incoming cell is the south neighbour of the centre tile above it
            if (row >= 1)
            begin
                centre   = centre_row[col];
                smoothed = centre;
                if (row != 1 && col != 0 && col != w - 1 && centre != KIND_SPECIAL)
                begin
                    n = int'(above_row[col] == KIND_OBSTACLE) + int'(west_kind == KIND_OBSTACLE)
                      + int'(centre_row[col + 1] == KIND_OBSTACLE)
                      + int'(kind == KIND_OBSTACLE);
                    if (n < survive_min)
                        smoothed = KIND_OPEN;
                    else if (n >= birth_min)
                        smoothed = KIND_OBSTACLE;
                end
                west_kind      = sync_mode ? centre : smoothed;
                above_row[col] = west_kind;
                queue_tile(smoothed, 1'b0, row != h - 1);
            end
            centre_row[col] = kind;
            if (row == h - 1)
                queue_tile(kind, col == w - 1, 1'b1);
            col++;
            if (col >= w)
            begin
                col = 0;
                row++;
                if (row >= h)
                    row = 0;
            end
        endfunction

        task report(string what);
            mismatch_count++;
            $display("mismatch at %0t: %s", $realtime, what);
        endtask

        task check_tile(logic [7:0] data, logic last, logic user);
            tile_t want;
            if (pending_tiles.size() == 0)
            begin
                report($sformatf("unexpected beat, tdata %0h", data));
                return;
            end
            want = pending_tiles.pop_front();
            if (data !== {{(8 - KIND_W){1'b0}}, want.kind})
                report($sformatf("new_kind %0h, expected %0d", data, want.kind));
            if (last !== want.frame_end)
                report($sformatf("frame_end %b, expected %b", last, want.frame_end));
            if (user !== want.run_last)
                report($sformatf("run_last %b, expected %b", user, want.run_last));
        endtask
    endclass

    logic               clk;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [7:0]         s_tdata;
    logic               s_tuser;
    logic               m_tvalid;
    logic               m_tready;
    logic [7:0]         m_tdata;
    logic               m_tlast;
    logic               m_tuser;
    logic               cfg_we;
    logic [IDX_W-1:0]   cfg_index;
    logic [CFG_W-1:0]   cfg_data;

    cave_grid_tracker grid = new();

    int          send_idle_pct;
    int          recv_idle_pct;
    bit          hold_req;
    int unsigned last_cols;
    int          stall_cycles;

    cave_automaton_smoothing u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // receiver: random back-pressure, plus one long hold-off on request
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                grid.check_tile(m_tdata, m_tlast, m_tuser);
        end
    end

    // watchdog: cycles with no beat on either stream
    initial
    begin
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic kind_t random_kind();
        int r;
        r = $urandom_range(99);
        if (r < 45)
            return KIND_OPEN;
        if (r < 85)
            return KIND_OBSTACLE;
        if (r < 90)
            return KIND_SPECIAL;
        return kind_t'($urandom_range(int'(KIND_SPECIAL) + 1, (1 << KIND_W) - 1));
    endfunction

    function automatic int unsigned random_threshold();
        return ($urandom_range(4) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4);
    endfunction

    task automatic write_reg(input logic [IDX_W-1:0] idx, input int unsigned value,
                             input int bits);
        logic [CFG_W-1:0] data;
        data = CFG_W'(value);
        // junk above the register width must be dropped
        if (bits < CFG_W && $urandom_range(3) == 0)
            data = data | (CFG_W'($urandom) << bits);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        grid.write_reg(idx, data);
    endtask

    task automatic set_registers(input bit mode, input int unsigned survive,
                                 input int unsigned birth, input int unsigned width_val,
                                 input int unsigned height_val);
        write_reg(REG_UPDATE_MODE, mode, 1);
        write_reg(REG_SURVIVAL, survive, THR_W);
        write_reg(REG_BIRTH, birth, THR_W);
        write_reg(REG_WIDTH, width_val, WIDTH_W);
        write_reg(REG_HEIGHT, height_val, HEIGHT_W);
        if ($urandom_range(1))
            write_reg(IDX_W'($urandom_range(int'(REG_HEIGHT) + 1, (1 << IDX_W) - 1)),
                      $urandom, CFG_W);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (grid.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic send_cell(input kind_t kind, input bit start);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(8 - KIND_W){1'b0}}, kind};
        s_tuser  <= start;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        grid.note_cell(kind, start);
    endtask

    // mostly whole frames; occasionally a frame without frame_start or a restart mid-frame
    task automatic run_cells(input int count, input bit first_start, input int hold_at,
                             input int drain_at);
        int frame_len;
        bit start;
        frame_len = grid.cols() * grid.rows();
        for (int i = 0; i < count; i++)
        begin
            if (i == hold_at)
                hold_req = 1'b1;
            if (i == drain_at)
                wait_drained();
            if (i == 0)
                start = first_start;
            else if (i % frame_len == 0)
                start = ($urandom_range(9) < 7);
            else
                start = ($urandom_range(199) == 0);
            send_cell(random_kind(), start);
        end
    endtask

    task automatic random_phase(input int drain_at);
        int unsigned width_val;
        int unsigned height_val;
        bit          restart;
        width_val  = ($urandom_range(9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
        height_val = ($urandom_range(9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 7);
        set_registers($urandom_range(1), random_threshold(), random_threshold(),
                      width_val, height_val);
        // a wider row would read line buffer entries the old width never wrote
        restart   = (grid.cols() > last_cols) || $urandom_range(1);
        last_cols = grid.cols();
        run_cells(grid.cols() * grid.rows() * $urandom_range(1, 2), restart, -1, drain_at);
        wait_drained();
    endtask

    initial
    begin
        kind_t pass_a [12];
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        hold_req  = 1'b0;
        last_cols = 0;
        send_idle_pct = 21;
        recv_idle_pct = 49;
        pass_a = '{3'd7, KIND_OBSTACLE, KIND_OBSTACLE, KIND_OPEN,
                   KIND_OBSTACLE, KIND_OPEN, KIND_SPECIAL, KIND_OBSTACLE,
                   KIND_OBSTACLE, KIND_OBSTACLE, KIND_OBSTACLE, 3'd6};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // 4x3 synchronous grid: birth on an interior cell, a special interior cell
        set_registers(1'b1, 2, 3, 4, 3);
        last_cols = grid.cols();
        foreach (pass_a[i])
            send_cell(pass_a[i], i == 0);
        wait_drained();

        // undersized grid saturates to 3x3, in-place, survival above 4 clears the centre;
        // then three cells wrap into a fresh top row without frame_start
        set_registers(1'b0, 5, 7, 2, 1);
        last_cols = grid.cols();
        for (int i = 0; i < 9; i++)
            send_cell(KIND_OBSTACLE, i == 0);
        send_cell(3'd3, 1'b0);
        send_cell(3'd4, 1'b0);
        send_cell(3'd5, 1'b0);
        wait_drained();

        random_phase(-1);

        // widest grid, one full frame
        set_registers($urandom_range(1), 2, 3, $urandom_range(1) ? 256 : 511, 3);
        last_cols = grid.cols();
        run_cells(grid.cols() * grid.rows(), 1'b1, -1, -1);
        wait_drained();

        send_idle_pct = 49;
        recv_idle_pct = 21;

        // tallest grid, partial; then shrink the height so the row counter wraps
        set_registers($urandom_range(1), 2, 3, 3, $urandom_range(1) ? 1024 : 2047);
        last_cols = grid.cols();
        run_cells(60, 1'b1, -1, -1);
        wait_drained();
        set_registers($urandom_range(1), random_threshold(), random_threshold(),
                      $urandom_range(0, 3), 4);
        run_cells(48, 1'b0, -1, -1);
        wait_drained();

        random_phase(5);
        random_phase(-1);

        send_idle_pct = 0;
        recv_idle_pct = 0;

        // long receiver hold-off while cells keep coming, so the input stalls
        set_registers($urandom_range(1), 2, 3, 8, 6);
        last_cols = grid.cols();
        run_cells(96, 1'b1, 20, -1);
        wait_drained();

        random_phase(-1);

        wait_drained();
        repeat (4 * DRAIN_CYCLES) @(posedge clk);
        if (grid.pending() != 0)
            grid.report($sformatf("%0d tiles never emitted", grid.pending()));
        if (grid.mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ files.f @@
rtl/cas_pkg.sv
rtl/cas_line_buf.sv
rtl/cas_cell_rule.sv
rtl/cave_automaton_smoothing.sv
rtl/cas_checker.sv
tb/sv/cave_automaton_smoothing_test.sv
